// File: rtl/pfp_pkg.sv
// shared types and constants of the particulate frame parser
package pfp_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;
    localparam int unsigned LEN_EXTRA      = 4;
    localparam int unsigned MIN_FRAME      = 18;
    localparam int unsigned FIRST_READ_OFF = 10;
    localparam int unsigned LAST_READ_OFF  = 15;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // what the back end does with one queued byte
    localparam logic [2:0] K_START  = 3'd0;
    localparam logic [2:0] K_SUM    = 3'd1;
    localparam logic [2:0] K_CKHI   = 3'd2;
    localparam logic [2:0] K_CKLO   = 3'd3;
    localparam logic [2:0] K_BADLEN = 3'd4;

    localparam logic [1:0] STATUS_GOOD   = 2'd0;
    localparam logic [1:0] STATUS_CKSUM  = 2'd1;
    localparam logic [1:0] STATUS_BADLEN = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       cap_hi;
    } pfp_item_t;

endpackage

// File: rtl/pfp_front.sv
// front end: header hunt, length check and byte classification
module pfp_front #(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_take,
    input  logic [7:0]        in_byte,
    output logic              push,
    output pfp_pkg::pfp_item_t push_item
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_HDR2  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [5:0]  total_reg, total_next;

    logic [16:0] total_calc;
    logic [6:0]  off_plus2;
    logic [5:0]  rel;
    logic        emit_item;
    pfp_pkg::pfp_item_t item;

    assign total_calc = {1'b0, len_hi_reg, in_byte} + 17'(pfp_pkg::LEN_EXTRA);
    assign off_plus2  = {1'b0, cnt_reg} + 7'd2;
    assign rel        = cnt_reg - 6'(pfp_pkg::FIRST_READ_OFF);

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        len_hi_next  = len_hi_reg;
        total_next   = total_reg;
        emit_item    = 1'b0;
        item.kind    = pfp_pkg::K_SUM;
        item.data    = in_byte;
        item.cap_en  = 1'b0;
        item.cap_idx = rel[2:1];
        item.cap_hi  = ~rel[0];
        unique case (phase_reg)
            PH_FRAME: begin
                emit_item = 1'b1;
                if (cnt_reg == 6'd2) begin
                    len_hi_next = in_byte;
                    cnt_next    = 6'd3;
                end else if (cnt_reg == 6'd3) begin
                    if (total_calc < 17'(pfp_pkg::MIN_FRAME) || total_calc > 17'(MAX_FRAME)) begin
                        item.kind  = pfp_pkg::K_BADLEN;
                        phase_next = PH_HUNT;
                    end else begin
                        total_next = total_calc[5:0];
                        cnt_next   = 6'd4;
                    end
                end else if (off_plus2 < {1'b0, total_reg}) begin
                    item.cap_en = (cnt_reg >= 6'(pfp_pkg::FIRST_READ_OFF))
                               && (cnt_reg <= 6'(pfp_pkg::LAST_READ_OFF));
                    cnt_next    = cnt_reg + 6'd1;
                end else if (off_plus2 == {1'b0, total_reg}) begin
                    item.kind = pfp_pkg::K_CKHI;
                    cnt_next  = cnt_reg + 6'd1;
                end else begin
                    item.kind  = pfp_pkg::K_CKLO;
                    phase_next = PH_HUNT;
                end
            end
            PH_HDR2: begin
                if (in_byte == pfp_pkg::HDR_SECOND) begin
                    emit_item  = 1'b1;
                    cnt_next   = 6'd2;
                    phase_next = PH_FRAME;
                end else if (in_byte == pfp_pkg::HDR_FIRST) begin
                    emit_item   = 1'b1;
                    item.kind   = pfp_pkg::K_START;
                    cnt_next    = 6'd1;
                    len_hi_next = 8'd0;
                    total_next  = 6'd0;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            default: begin
                if (in_byte == pfp_pkg::HDR_FIRST) begin
                    emit_item   = 1'b1;
                    item.kind   = pfp_pkg::K_START;
                    phase_next  = PH_HDR2;
                    cnt_next    = 6'd1;
                    len_hi_next = 8'd0;
                    total_next  = 6'd0;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign push      = in_take && emit_item;
    assign push_item = item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            cnt_reg    <= 6'd0;
            len_hi_reg <= 8'd0;
            total_reg  <= 6'd0;
        end else if (in_take) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            len_hi_reg <= len_hi_next;
            total_reg  <= total_next;
        end
    end

endmodule

// File: rtl/pfp_queue.sv
// short queue of classified bytes between front and back end
module pfp_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pfp_pkg::pfp_item_t push_item,
    output logic               full,
    input  logic               pop,
    output pfp_pkg::pfp_item_t pop_item,
    output logic               empty
);

    pfp_pkg::pfp_item_t            slots [pfp_pkg::QUEUE_DEPTH];
    logic [pfp_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [pfp_pkg::QCNT_W-1:0]    count_reg;

    assign full     = (count_reg == pfp_pkg::QCNT_W'(pfp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/pfp_back.sv
// back end: checksum, reading capture and result register
module pfp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  pfp_pkg::pfp_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [47:0]        out_data,
    output logic [1:0]         out_status
);

    logic [15:0] sum_reg;
    logic [7:0]  exp_hi_reg;
    logic [15:0] rd_reg [3];
    logic        out_valid_reg;
    logic [47:0] out_data_reg;
    logic [1:0]  out_status_reg;
    logic        emits;
    logic        good;

    assign emits = (q_item.kind == pfp_pkg::K_CKLO) || (q_item.kind == pfp_pkg::K_BADLEN);
    assign q_pop = !q_empty && (!emits || !out_valid_reg || out_ready);
    assign good  = ({exp_hi_reg, q_item.data} == sum_reg);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            unique case (q_item.kind)
                pfp_pkg::K_START: begin
                    sum_reg   <= {8'd0, q_item.data};
                    rd_reg[0] <= 16'd0;
                    rd_reg[1] <= 16'd0;
                    rd_reg[2] <= 16'd0;
                end
                pfp_pkg::K_SUM: begin
                    sum_reg <= sum_reg + {8'd0, q_item.data};
                    if (q_item.cap_en) begin
                        if (q_item.cap_hi) begin
                            rd_reg[q_item.cap_idx][15:8] <= q_item.data;
                        end else begin
                            rd_reg[q_item.cap_idx][7:0] <= q_item.data;
                        end
                    end
                end
                pfp_pkg::K_CKHI: begin
                    exp_hi_reg <= q_item.data;
                end
                pfp_pkg::K_CKLO: begin
                    out_data_reg   <= good ? {rd_reg[2], rd_reg[1], rd_reg[0]} : 48'd0;
                    out_status_reg <= good ? pfp_pkg::STATUS_GOOD : pfp_pkg::STATUS_CKSUM;
                end
                pfp_pkg::K_BADLEN: begin
                    out_data_reg   <= 48'd0;
                    out_status_reg <= pfp_pkg::STATUS_BADLEN;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop && emits) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

// File: rtl/particulate_frame_parser.sv
// top level of the particulate sensor serial frame parser
// usage:
//   s_* takes one received byte per beat (s_tdata). the parser hunts for the
//   start pair 0x42 0x4d, reads the big-endian length, sums the frame and picks
//   up the three readings at frame offsets 10..15.
//   m_* gives one beat per finished frame or per bad declared length:
//   m_tdata holds the readings, m_tuser the status (0 good, 1 checksum
//   mismatch, 2 bad length); readings are zero unless the status is good.
// throughput and data path:
//   one byte per cycle sustained while the queue is not full; the front end
//   classifies a byte as it is accepted and writes it to the queue; the back
//   end then pops it, which also loads the result register and m_tvalid.
//   it retires one byte per cycle but stalls a result byte while m_tvalid waits.
// reset and stalls:
//   aresetn clears the hunt state, the queue and the result valid.
//   while m_tready is low the result register holds; the four-entry queue
//   keeps taking bytes until it fills, then s_tready drops.
module particulate_frame_parser #(
    parameter int unsigned MAX_FRAME = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] pm1_reading, [31:16] pm25_reading, [47:32] pm10_reading
    output logic [1:0]  m_tuser    // [1:0] frame_status
);

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    pfp_pkg::pfp_item_t push_item;
    pfp_pkg::pfp_item_t pop_item;

    assign s_tready = !q_full;

    pfp_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_take   (s_tvalid && s_tready),
        .in_byte   (s_tdata),
        .push      (q_push),
        .push_item (push_item)
    );

    pfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    pfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

// File: rtl/pfp_checker.sv
// port-level checks of the particulate frame parser and their binding
module pfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // failed frames carry no readings
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != pfp_pkg::STATUS_GOOD |-> m_tdata == 48'd0)
        else $error("readings not zero on failed frame");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == pfp_pkg::STATUS_GOOD || m_tuser == pfp_pkg::STATUS_CKSUM
                     || m_tuser == pfp_pkg::STATUS_BADLEN)
        else $error("unknown frame status");

    // reset empties the result register and the queue
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked after reset");

    // the first byte accepted after reset cannot finish a frame by itself
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |=> !m_tvalid)
        else $error("result too early after reset");

endmodule

bind particulate_frame_parser pfp_checker u_pfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/tb.sv
// self-checking testbench for the particulate frame parser
`timescale 1ns / 100ps

typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_IN_FRAME    = 2'd2
} hunt_phase_t;

typedef struct {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [1:0]  status;
} frame_result_t;

typedef logic [7:0] byte_q_t[$];

class pm_frame_tracker #(int unsigned MAX_LEN = 32);
    hunt_phase_t   phase     = PH_HUNT_FIRST;
    logic [5:0]    byte_off  = '0;
    logic [7:0]    len_hi    = '0;
    logic [5:0]    total_len = '0;
    logic [15:0]   frame_sum = '0;
    logic [7:0]    ck_hi     = '0;
    logic [15:0]   rd[3]     = '{default: '0};
    frame_result_t results_due[$];
    int            mismatch_count = 0;

    function void start_frame();
        phase     = PH_HUNT_SECOND;
        byte_off  = 6'd1;
        frame_sum = 16'(pfp_pkg::HDR_FIRST);
        len_hi    = '0;
        total_len = '0;
        ck_hi     = '0;
        rd        = '{default: '0};
    endfunction

    function void push_result(logic [1:0] status, bit with_readings);
        frame_result_t r;
        r.pm1    = with_readings ? rd[0] : 16'h0;
        r.pm25   = with_readings ? rd[1] : 16'h0;
        r.pm10   = with_readings ? rd[2] : 16'h0;
        r.status = status;
        results_due.push_back(r);
        phase = PH_HUNT_FIRST;
    endfunction

    // one accepted input beat
    function void take_byte(logic [7:0] b);
        int unsigned off;
        int unsigned full_len;
        int unsigned idx;
        case (phase)
            PH_HUNT_SECOND: begin
                if (b == pfp_pkg::HDR_SECOND) begin
                    frame_sum = frame_sum + b;
                    byte_off  = 6'd2;
                    phase     = PH_IN_FRAME;
                end else if (b == pfp_pkg::HDR_FIRST) begin
                    start_frame();
                end else begin
                    phase = PH_HUNT_FIRST;
                end
            end
            PH_IN_FRAME: begin
                off = byte_off;
                if (off == 2) begin
                    len_hi    = b;
                    frame_sum = frame_sum + b;
                    byte_off  = 6'd3;
                end else if (off == 3) begin
                    full_len  = {len_hi, b} + pfp_pkg::LEN_EXTRA;
                    frame_sum = frame_sum + b;
                    if (full_len < pfp_pkg::MIN_FRAME || full_len > MAX_LEN) begin
                        push_result(pfp_pkg::STATUS_BADLEN, 1'b0);
                    end else begin
                        total_len = full_len[5:0];
                        byte_off  = 6'd4;
                    end
                end else if (off + 2 < total_len) begin
                    frame_sum = frame_sum + b;
                    if (off >= pfp_pkg::FIRST_READ_OFF && off <= pfp_pkg::LAST_READ_OFF) begin
                        idx = (off - pfp_pkg::FIRST_READ_OFF) >> 1;
                        if (((off - pfp_pkg::FIRST_READ_OFF) & 1) == 0)
                            rd[idx][15:8] = b;
                        else
                            rd[idx][7:0] = b;
                    end
                    byte_off = 6'(off + 1);
                end else if (off + 2 == total_len) begin
                    ck_hi    = b;
                    byte_off = 6'(off + 1);
                end else if ({ck_hi, b} == frame_sum) begin
                    push_result(pfp_pkg::STATUS_GOOD, 1'b1);
                end else begin
                    push_result(pfp_pkg::STATUS_CKSUM, 1'b0);
                end
            end
            default: begin
                if (b == pfp_pkg::HDR_FIRST)
                    start_frame();
                else
                    phase = PH_HUNT_FIRST;
            end
        endcase
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // one accepted result beat
    function void match_report(logic [47:0] data, logic [1:0] status);
        frame_result_t want;
        if (results_due.size() == 0) begin
            $error("result beat with nothing outstanding: tdata %h tuser %0d", data, status);
            mismatch_count++;
            return;
        end
        want = results_due.pop_front();
        cmp_field("pm1_reading", want.pm1, data[15:0]);
        cmp_field("pm25_reading", want.pm25, data[31:16]);
        cmp_field("pm10_reading", want.pm10, data[47:32]);
        cmp_field("frame_status", 16'(want.status), 16'(status));
    endfunction

    function int outstanding();
        return results_due.size();
    endfunction

    function void flag_leftovers();
        if (results_due.size() != 0) begin
            $error("%0d results never arrived", results_due.size());
            mismatch_count++;
        end
    endfunction
endclass

module tb;

    localparam int unsigned MAX_FRAME   = 32;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          BYTE_TARGET = 1800;
    localparam int          HOLD_CYCLES = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;   // [15:0] pm1_reading, [31:16] pm25_reading, [47:32] pm10_reading
    logic [1:0]  m_tuser;   // [1:0] frame_status

    pm_frame_tracker #(MAX_FRAME) track = new;

    bit no_idle     = 1'b0;
    bit hold_rx_req = 1'b0;
    int bytes_sent  = 0;
    int cycles      = 0;

    particulate_frame_parser #(.MAX_FRAME(MAX_FRAME)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            track.match_report(m_tdata, m_tuser);
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_rx_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx_req = 1'b0;
            end else if (pick_gap() != 0) begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // checksum covers every byte so far; a bad one gets a single flipped bit
    function automatic byte_q_t append_check(byte_q_t q, bit bad_sum);
        logic [15:0] sum;
        sum = '0;
        foreach (q[i]) sum = sum + q[i];
        if (bad_sum)
            sum = sum ^ (16'h1 << $urandom_range(0, 15));
        q.push_back(sum[15:8]);
        q.push_back(sum[7:0]);
        return q;
    endfunction

    function automatic byte_q_t build_frame(int unsigned total, bit bad_sum);
        byte_q_t     q;
        logic [15:0] len;
        len = 16'(total - pfp_pkg::LEN_EXTRA);
        q = {pfp_pkg::HDR_FIRST, pfp_pkg::HDR_SECOND, len[15:8], len[7:0]};
        for (int unsigned off = 4; off + 2 < total; off++)
            q.push_back(rand_byte());
        return append_check(q, bad_sum);
    endfunction

    function automatic int unsigned good_total();
        case ($urandom_range(0, 4))
            0:       return pfp_pkg::MIN_FRAME;
            1:       return MAX_FRAME;
            default: return $urandom_range(pfp_pkg::MIN_FRAME, MAX_FRAME);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        track.take_byte(b);
        bytes_sent++;
    endtask

    task automatic send_bytes(input byte_q_t q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (track.outstanding() != 0) @(posedge aclk);
    endtask

    initial begin
        byte_q_t     q;
        logic [15:0] len;
        int unsigned pick;
        int unsigned cut;
        int          frame_idx;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: header restart, 0x42 retaken, bad lengths, minimum frame
        no_idle = 1'b1;
        send_bytes({pfp_pkg::HDR_FIRST, 8'h41});
        send_bytes({pfp_pkg::HDR_FIRST, pfp_pkg::HDR_FIRST, pfp_pkg::HDR_SECOND, 8'h00,
                    8'(pfp_pkg::MIN_FRAME - pfp_pkg::LEN_EXTRA - 1)});
        send_bytes({pfp_pkg::HDR_FIRST, pfp_pkg::HDR_SECOND, 8'hFF, 8'hFF});
        q = {pfp_pkg::HDR_FIRST, pfp_pkg::HDR_SECOND, 8'h00,
             8'(pfp_pkg::MIN_FRAME - pfp_pkg::LEN_EXTRA)};
        repeat (pfp_pkg::MIN_FRAME - 6) q.push_back(8'hFF);
        send_bytes(append_check(q, 1'b0));
        no_idle = 1'b0;
        send_bytes(build_frame(MAX_FRAME, 1'b1));

        frame_idx = 0;
        while (bytes_sent < BYTE_TARGET) begin
            no_idle = ($urandom_range(0, 99) < 15);
            if (frame_idx == 20) begin
                // receiver holds off while frames keep coming back to back
                no_idle = 1'b1;
                hold_rx_req = 1'b1;
                repeat (4) send_bytes(build_frame(MAX_FRAME, 1'b0));
            end
            if (frame_idx % 25 == 24)
                wait_results_drained();
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                send_bytes(build_frame(good_total(), 1'b0));
            end else if (pick < 75) begin
                send_bytes(build_frame(good_total(), 1'b1));
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0:       len = 16'(pfp_pkg::MIN_FRAME - pfp_pkg::LEN_EXTRA - 1);
                    1:       len = 16'(MAX_FRAME - pfp_pkg::LEN_EXTRA + 1);
                    2:       len = 16'($urandom_range(0,
                                   pfp_pkg::MIN_FRAME - pfp_pkg::LEN_EXTRA - 1));
                    default: len = 16'($urandom_range(256, 65535));
                endcase
                send_bytes({pfp_pkg::HDR_FIRST, pfp_pkg::HDR_SECOND, len[15:8], len[7:0]});
            end else if (pick < 93) begin
                q = build_frame(good_total(), 1'b0);
                cut = $urandom_range(3, q.size() - 1);
                q = q[0:cut-1];
                send_bytes(q);
            end else begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 4) == 0) ? pfp_pkg::HDR_FIRST : rand_byte());
            end
            frame_idx++;
        end

        s_tvalid <= 1'b0;
        wait_results_drained();
        repeat (10) @(posedge aclk);
        track.flag_leftovers();
        if (track.mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
